>>> rtl/http_chunked_body_decoder_core_defines.svh
// assertion helpers for the chunked body decoder
// each expects signals named clk and rst in the scope of use
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HCBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hcbd_pkg.sv
package hcbd_pkg;

  // decoder phase
  typedef enum logic [3:0] {
    PH_SIZE_SP  = 4'd0,
    PH_SIZE_HEX = 4'd1,
    PH_SIZE_EXT = 4'd2,
    PH_DATA     = 4'd3,
    PH_DATA_EOL = 4'd4,
    PH_TR_START = 4'd5,
    PH_TR_NAME  = 4'd6,
    PH_TR_VALUE = 4'd7,
    PH_DONE     = 4'd8,
    PH_ERROR    = 4'd9
  } hcbd_phase_t;

  // result kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // ascii codes
  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_SP    = 8'h20;
  localparam logic [7:0] CHR_HT    = 8'h09;
  localparam logic [7:0] CHR_COLON = 8'h3a;
  localparam logic [7:0] CHR_DEL   = 8'h7f;

  // reset value of the line length limit
  localparam logic [15:0] MAX_LINE_LEN_RESET = 16'd4096;

  // line parser control state
  typedef struct packed {
    hcbd_phase_t phase;
    logic        saw_cr;
    logic [15:0] line_len;
  } hcbd_ctl_t;

  // one result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       chunk_end;
  } hcbd_res_t;

endpackage

>>> rtl/hcbd_step.sv
module hcbd_step #(
  parameter int SIZE_BITS = 32
) (
  input  logic [7:0]            in_byte,
  input  logic                  begin_body,
  input  logic [15:0]           max_line_len,
  input  hcbd_pkg::hcbd_ctl_t   ctl,
  input  logic [SIZE_BITS-1:0]  bytes_left,
  input  logic [SIZE_BITS-1:0]  size_accum,
  output hcbd_pkg::hcbd_ctl_t   ctl_next,
  output logic [SIZE_BITS-1:0]  bytes_left_next,
  output logic [SIZE_BITS-1:0]  size_accum_next,
  output hcbd_pkg::hcbd_res_t   res
);

  // hex digit decode: bit 4 is valid, low bits the value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {["0":"9"]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {["a":"f"]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {["A":"F"]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  hcbd_pkg::hcbd_ctl_t  cur;
  logic [SIZE_BITS-1:0] bl;
  logic [SIZE_BITS-1:0] sa;
  logic [4:0]           hex;
  logic                 ovf;
  logic                 eol;

  // one byte through the line state machine
  always_comb begin
    cur = ctl;
    bl  = bytes_left;
    sa  = size_accum;
    if (begin_body) begin
      cur.phase    = hcbd_pkg::PH_SIZE_SP;
      cur.saw_cr   = 1'b0;
      cur.line_len = '0;
      bl           = '0;
      sa           = '0;
    end

    hex = hex_digit(in_byte);
    ovf = (sa[SIZE_BITS-1 -: 4] != 4'd0);
    eol = cur.saw_cr && (in_byte == hcbd_pkg::CHR_LF);

    ctl_next        = cur;
    bytes_left_next = bl;
    size_accum_next = sa;
    res.kind        = hcbd_pkg::KIND_NONE;
    res.data        = 8'd0;
    res.chunk_end   = 1'b0;

    case (cur.phase)
      hcbd_pkg::PH_ERROR, hcbd_pkg::PH_DONE: begin
      end
      hcbd_pkg::PH_DATA: begin
        res.kind        = hcbd_pkg::KIND_DATA;
        res.data        = in_byte;
        bytes_left_next = bl - 1'b1;
        if (bl == SIZE_BITS'(1)) begin
          res.chunk_end     = 1'b1;
          ctl_next.phase    = hcbd_pkg::PH_DATA_EOL;
          ctl_next.saw_cr   = 1'b0;
          ctl_next.line_len = '0;
        end
      end
      default: begin
        if (cur.line_len >= max_line_len) begin
          ctl_next.phase = hcbd_pkg::PH_ERROR;
        end else begin
          ctl_next.line_len = cur.line_len + 16'd1;
          if (eol) begin
            // crlf closes the line
            ctl_next.saw_cr   = 1'b0;
            ctl_next.line_len = '0;
            case (cur.phase)
              hcbd_pkg::PH_SIZE_SP, hcbd_pkg::PH_SIZE_HEX, hcbd_pkg::PH_SIZE_EXT: begin
                if (sa != '0) begin
                  bytes_left_next = sa;
                  ctl_next.phase  = hcbd_pkg::PH_DATA;
                end else begin
                  ctl_next.phase  = hcbd_pkg::PH_TR_START;
                end
                size_accum_next = '0;
              end
              hcbd_pkg::PH_DATA_EOL: ctl_next.phase = hcbd_pkg::PH_SIZE_SP;
              hcbd_pkg::PH_TR_START: begin
                ctl_next.phase = hcbd_pkg::PH_DONE;
                res.kind       = hcbd_pkg::KIND_DONE;
              end
              hcbd_pkg::PH_TR_VALUE: ctl_next.phase = hcbd_pkg::PH_TR_START;
              default: ctl_next.phase = hcbd_pkg::PH_ERROR;
            endcase
          end else if ((cur.phase == hcbd_pkg::PH_TR_START) && cur.saw_cr) begin
            // held cr at trailer start not followed by lf
            ctl_next.phase = hcbd_pkg::PH_ERROR;
          end else begin
            ctl_next.saw_cr = (in_byte == hcbd_pkg::CHR_CR);
            case (cur.phase)
              hcbd_pkg::PH_SIZE_SP: begin
                if ((in_byte == hcbd_pkg::CHR_SP) || (in_byte == hcbd_pkg::CHR_HT)) begin
                end else if (hex[4]) begin
                  if (ovf) begin
                    ctl_next.phase = hcbd_pkg::PH_ERROR;
                  end else begin
                    size_accum_next = {sa[SIZE_BITS-5:0], hex[3:0]};
                    ctl_next.phase  = hcbd_pkg::PH_SIZE_HEX;
                  end
                end else begin
                  ctl_next.phase = hcbd_pkg::PH_SIZE_EXT;
                end
              end
              hcbd_pkg::PH_SIZE_HEX: begin
                if (hex[4]) begin
                  if (ovf) begin
                    ctl_next.phase = hcbd_pkg::PH_ERROR;
                  end else begin
                    size_accum_next = {sa[SIZE_BITS-5:0], hex[3:0]};
                  end
                end else begin
                  ctl_next.phase = hcbd_pkg::PH_SIZE_EXT;
                end
              end
              hcbd_pkg::PH_TR_START: begin
                if (in_byte == hcbd_pkg::CHR_CR) begin
                end else if (in_byte == hcbd_pkg::CHR_COLON) begin
                  ctl_next.phase = hcbd_pkg::PH_TR_VALUE;
                end else if (in_byte inside {[8'd0:8'd32], hcbd_pkg::CHR_DEL}) begin
                  ctl_next.phase = hcbd_pkg::PH_ERROR;
                end else begin
                  ctl_next.phase = hcbd_pkg::PH_TR_NAME;
                end
              end
              hcbd_pkg::PH_TR_NAME: begin
                if (in_byte == hcbd_pkg::CHR_COLON) begin
                  ctl_next.phase = hcbd_pkg::PH_TR_VALUE;
                end else if (in_byte inside {[8'd0:8'd32], hcbd_pkg::CHR_DEL}) begin
                  ctl_next.phase = hcbd_pkg::PH_ERROR;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    endcase

    // error is sticky and masks the result
    if (ctl_next.phase == hcbd_pkg::PH_ERROR) begin
      res.kind      = hcbd_pkg::KIND_ERROR;
      res.data      = 8'd0;
      res.chunk_end = 1'b0;
    end
  end

endmodule

>>> rtl/http_chunked_body_decoder_core.sv
// Chunked HTTP body decoder, one raw body byte in, one result item out.
// Input stream: s_axis_tdata carries the raw byte, s_axis_tuser set restarts
// the decoder at a fresh chunk-size line before that byte is parsed.
// Output stream: m_axis_tuser is the kind (none, data, body complete, error),
// m_axis_tdata the payload byte for data items (zero otherwise), m_axis_tlast
// marks the last data byte of a chunk. Every input item gives exactly one
// output item, including kind none for framing bytes.
// max_line_len is written through cfg_we / cfg_wdata; write it only while idle.
// An accepted item is held in the input register and its result is registered
// in the result register when the pipeline advances. The block takes one item
// per cycle while the receiver keeps up, set by the combinational parser
// update between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// fills; s_axis_tready then drops until the result is taken.
// Reset (rst, synchronous) empties both registers, puts the parser at the start
// of a size line and sets max_line_len to 4096.
`include "http_chunked_body_decoder_core_defines.svh"

module http_chunked_body_decoder_core #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] begin_body
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast,   // chunk_end
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata       // [15:0] max_line_len
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 in_begin;
  logic                 advance;
  logic [15:0]          max_line_len;
  hcbd_pkg::hcbd_ctl_t  ctl;
  hcbd_pkg::hcbd_ctl_t  ctl_next;
  logic [SIZE_BITS-1:0] bytes_left;
  logic [SIZE_BITS-1:0] bytes_left_next;
  logic [SIZE_BITS-1:0] size_accum;
  logic [SIZE_BITS-1:0] size_accum_next;
  hcbd_pkg::hcbd_res_t  res;
  hcbd_pkg::hcbd_res_t  out_res;
  logic                 out_valid;

  // pipeline moves when the result register is free or being taken
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_len <= hcbd_pkg::MAX_LINE_LEN_RESET;
    end else if (cfg_we) begin
      max_line_len <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_begin <= s_axis_tuser;
    end
  end

  // parser update
  hcbd_step #(
    .SIZE_BITS (SIZE_BITS)
  ) u_step (
    .in_byte         (in_byte),
    .begin_body      (in_begin),
    .max_line_len    (max_line_len),
    .ctl             (ctl),
    .bytes_left      (bytes_left),
    .size_accum      (size_accum),
    .ctl_next        (ctl_next),
    .bytes_left_next (bytes_left_next),
    .size_accum_next (size_accum_next),
    .res             (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl        <= '{phase: hcbd_pkg::PH_SIZE_SP, saw_cr: 1'b0, line_len: 16'd0};
      bytes_left <= '0;
      size_accum <= '0;
    end else if (advance) begin
      ctl        <= ctl_next;
      bytes_left <= bytes_left_next;
      size_accum <= size_accum_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.data;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.chunk_end;

  // checks
  `HCBD_ASSERT_NOW(a_last_is_data, m_axis_tvalid && m_axis_tlast,
                   m_axis_tuser == hcbd_pkg::KIND_DATA, "chunk end on a non-data item")
  `HCBD_ASSERT_NOW(a_nondata_zero, m_axis_tvalid && (m_axis_tuser != hcbd_pkg::KIND_DATA),
                   m_axis_tdata == 8'd0, "payload byte on a non-data item")
  `HCBD_ASSERT_NEXT(a_error_sticky,
                    advance && (ctl.phase == hcbd_pkg::PH_ERROR) && !in_begin,
                    ctl.phase == hcbd_pkg::PH_ERROR, "error state left without restart")
  `HCBD_ASSERT_NOW(a_ready_when_empty, !out_valid, s_axis_tready,
                   "input stalled with empty result register")

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int SIZE_BITS   = 32;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic        s_axis_tuser = 1'b0;    // [0] begin_body
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] out_byte
  logic [1:0]  m_axis_tuser;           // [1:0] out_kind
  logic        m_axis_tlast;           // chunk_end
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;   // [15:0] max_line_len

  http_chunked_body_decoder_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // decoder state as the block should hold it
  hcbd_pkg::hcbd_phase_t ph;
  logic [SIZE_BITS-1:0]  chunk_left;
  logic [SIZE_BITS-1:0]  size_acc;
  logic                  cr_seen;
  logic [15:0]           line_cnt;
  logic [15:0]           line_limit;

  hcbd_pkg::hcbd_res_t   pending_results[$];
  logic [7:0]            body_q[$];
  hcbd_pkg::hcbd_res_t   want;
  int                    errors = 0;
  int                    items_sent = 0;
  int                    burst_left = 0;
  int                    cycles = 0;
  int                    rdy_mode = 0;
  int                    rdy_run = 0;

  function automatic void clear_parser();
    ph         = hcbd_pkg::PH_SIZE_SP;
    chunk_left = '0;
    size_acc   = '0;
    cr_seen    = 1'b0;
    line_cnt   = '0;
  endfunction

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    if (b >= "0" && b <= "9") begin
      t = b - "0";
      return {1'b1, t[3:0]};
    end
    if (b >= "a" && b <= "f") begin
      t = b - "a" + 8'd10;
      return {1'b1, t[3:0]};
    end
    if (b >= "A" && b <= "F") begin
      t = b - "A" + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'b0;
  endfunction

  // false when the digit would push the size past SIZE_BITS
  function automatic bit push_digit(input logic [3:0] d);
    if (size_acc[SIZE_BITS-1 -: 4] != 4'h0) return 1'b0;
    size_acc = {size_acc[SIZE_BITS-5:0], d};
    return 1'b1;
  endfunction

  // advance the expected decoder by one body byte
  function automatic hcbd_pkg::hcbd_res_t decode_byte(input logic [7:0] b,
                                                      input logic restart_body);
    hcbd_pkg::hcbd_res_t r;
    logic [4:0]          nib;
    r = '0;
    if (restart_body) clear_parser();
    case (ph)
      hcbd_pkg::PH_ERROR, hcbd_pkg::PH_DONE: begin
      end
      hcbd_pkg::PH_DATA: begin
        r.kind = hcbd_pkg::KIND_DATA;
        r.data = b;
        chunk_left = chunk_left - 1'b1;
        if (chunk_left == '0) begin
          r.chunk_end = 1'b1;
          ph = hcbd_pkg::PH_DATA_EOL;
          cr_seen = 1'b0;
          line_cnt = '0;
        end
      end
      default: begin
        if (line_cnt >= line_limit) begin
          ph = hcbd_pkg::PH_ERROR;
        end else begin
          line_cnt = line_cnt + 16'd1;
          if (cr_seen && b == hcbd_pkg::CHR_LF) begin
            // end of line
            cr_seen = 1'b0;
            line_cnt = '0;
            case (ph)
              hcbd_pkg::PH_SIZE_SP, hcbd_pkg::PH_SIZE_HEX, hcbd_pkg::PH_SIZE_EXT: begin
                if (size_acc != '0) begin
                  chunk_left = size_acc;
                  ph = hcbd_pkg::PH_DATA;
                end else begin
                  ph = hcbd_pkg::PH_TR_START;
                end
                size_acc = '0;
              end
              hcbd_pkg::PH_DATA_EOL: ph = hcbd_pkg::PH_SIZE_SP;
              hcbd_pkg::PH_TR_START: begin
                ph = hcbd_pkg::PH_DONE;
                r.kind = hcbd_pkg::KIND_DONE;
              end
              hcbd_pkg::PH_TR_VALUE: ph = hcbd_pkg::PH_TR_START;
              default: ph = hcbd_pkg::PH_ERROR;
            endcase
          end else if (ph == hcbd_pkg::PH_TR_START && cr_seen) begin
            // held cr not followed by lf
            ph = hcbd_pkg::PH_ERROR;
          end else begin
            cr_seen = (b == hcbd_pkg::CHR_CR);
            nib = hex_nibble(b);
            case (ph)
              hcbd_pkg::PH_SIZE_SP: begin
                if (b != hcbd_pkg::CHR_SP && b != hcbd_pkg::CHR_HT) begin
                  if (nib[4]) begin
                    ph = push_digit(nib[3:0]) ? hcbd_pkg::PH_SIZE_HEX : hcbd_pkg::PH_ERROR;
                  end else begin
                    ph = hcbd_pkg::PH_SIZE_EXT;
                  end
                end
              end
              hcbd_pkg::PH_SIZE_HEX: begin
                if (nib[4]) begin
                  if (!push_digit(nib[3:0])) ph = hcbd_pkg::PH_ERROR;
                end else begin
                  ph = hcbd_pkg::PH_SIZE_EXT;
                end
              end
              hcbd_pkg::PH_TR_START: begin
                if (b == hcbd_pkg::CHR_COLON) ph = hcbd_pkg::PH_TR_VALUE;
                else if (b == hcbd_pkg::CHR_CR) ph = hcbd_pkg::PH_TR_START;
                else if (b <= hcbd_pkg::CHR_SP || b == hcbd_pkg::CHR_DEL) ph = hcbd_pkg::PH_ERROR;
                else ph = hcbd_pkg::PH_TR_NAME;
              end
              hcbd_pkg::PH_TR_NAME: begin
                if (b == hcbd_pkg::CHR_COLON) ph = hcbd_pkg::PH_TR_VALUE;
                else if (b <= hcbd_pkg::CHR_SP || b == hcbd_pkg::CHR_DEL) ph = hcbd_pkg::PH_ERROR;
              end
              default: begin
              end
            endcase
          end
        end
      end
    endcase
    if (ph == hcbd_pkg::PH_ERROR) begin
      r = '{kind: hcbd_pkg::KIND_ERROR, data: 8'h00, chunk_end: 1'b0};
    end
    return r;
  endfunction

  // sender: bursts of items with random gaps in between
  task automatic send_item(input logic [7:0] b, input logic restart_body);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= restart_body;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(decode_byte(b, restart_body));
    items_sent++;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    body_q.push_back(b);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  function automatic void add_eol();
    body_q.push_back(hcbd_pkg::CHR_CR);
    body_q.push_back(hcbd_pkg::CHR_LF);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // size digits, sometimes with leading zeros
  task automatic add_hex(input logic [31:0] v);
    int top;
    bit upper;
    upper = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) add_byte(hex_char(4'h0, upper));
    top = 7;
    while (top > 0 && v[top*4 +: 4] == 4'h0) top--;
    for (int n = top; n >= 0; n--) add_byte(hex_char(v[n*4 +: 4], upper));
  endtask

  // send the collected body, restart on its first item if asked and at random now and then
  task automatic send_body(input bit with_restart);
    for (int i = 0; i < body_q.size(); i++)
      send_item(body_q[i], (with_restart && i == 0) || ($urandom_range(0, 199) == 0));
    body_q.delete();
  endtask

  // pause until every expected result is back and the pipe is empty
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_line_limit(input logic [15:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    line_limit = v;
  endtask

  // well-formed body with random content, sometimes damaged or pure noise
  task automatic build_random_body();
    int         n_chunks;
    int         n_trailers;
    int         sz;
    int         k;
    logic [7:0] b;
    logic [7:0] prev;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    n_chunks = $urandom_range(0, 3);
    for (int i = 0; i < n_chunks; i++) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2))
          add_byte($urandom_range(0, 1) ? hcbd_pkg::CHR_SP : hcbd_pkg::CHR_HT);
      if ($urandom_range(0, 24) == 0) begin
        // nine digits, the last one overflows the size
        add_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
        repeat (8) add_byte(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
        sz = $urandom_range(0, 4);
      end else begin
        sz = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 300) : $urandom_range(1, 12);
        add_hex(sz);
      end
      if ($urandom_range(0, 9) == 0)
        add_byte($urandom_range(0, 1) ? hcbd_pkg::CHR_LF : hcbd_pkg::CHR_CR);
      if ($urandom_range(0, 3) == 0) begin
        add_text(";");
        repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(32, 255)));
      end
      add_eol();
      repeat (sz) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(32, 255)));
      add_eol();
    end
    // last chunk, a zero or an empty size line
    if ($urandom_range(0, 3) != 0) add_hex(32'h0);
    if ($urandom_range(0, 5) == 0) add_text(";ext");
    add_eol();
    n_trailers = $urandom_range(0, 2);
    for (int i = 0; i < n_trailers; i++) begin
      k = $urandom_range(0, 5);
      for (int j = 0; j < k; j++) begin
        case ($urandom_range(0, 5))
          0:       b = 8'($urandom_range(128, 255));
          1:       b = "-";
          default: b = 8'($urandom_range(8'h61, 8'h7a));
        endcase
        add_byte(b);
      end
      // bad name byte now and then
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       add_byte(hcbd_pkg::CHR_SP);
          1:       add_byte(hcbd_pkg::CHR_HT);
          2:       add_byte(8'($urandom_range(0, 31)));
          default: add_byte(hcbd_pkg::CHR_DEL);
        endcase
      end
      add_byte(hcbd_pkg::CHR_COLON);
      prev = 8'h00;
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        if (prev == hcbd_pkg::CHR_CR && b == hcbd_pkg::CHR_LF) b = "x";
        add_byte(b);
        prev = b;
      end
      add_eol();
    end
    add_eol();
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
    // damage a few bytes
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3))
        body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  // two data extremes, empty size line, high-byte trailer name, completion, byte after it
  task automatic test_simple_body();
    add_text("2");
    add_eol();
    add_byte(8'h00);
    add_byte(8'hff);
    add_eol();
    add_eol();
    add_byte(8'h80);
    add_byte(hcbd_pkg::CHR_COLON);
    add_eol();
    add_eol();
    add_byte(8'h00);
    send_body(1'b1);
  endtask

  // bad trailer starts and names, error stays until restart
  task automatic test_trailer_faults();
    add_eol();
    add_byte(hcbd_pkg::CHR_SP);
    add_byte("A");
    send_body(1'b1);
    add_eol();
    add_byte(hcbd_pkg::CHR_CR);
    add_byte("A");
    send_body(1'b1);
    add_eol();
    add_byte(hcbd_pkg::CHR_COLON);
    add_byte(hcbd_pkg::CHR_DEL);
    add_eol();
    add_text("a");
    add_byte(hcbd_pkg::CHR_DEL);
    send_body(1'b1);
  endtask

  // ninth significant digit overflows the size
  task automatic test_size_overflow();
    add_text("10000000");
    add_text("0");
    send_body(1'b1);
  endtask

  // at the smallest limit only a bare crlf fits in a line
  task automatic test_line_limit();
    add_eol();
    add_eol();
    send_body(1'b1);
    add_text("0");
    add_eol();
    send_body(1'b1);
  endtask

  task automatic test_random_bodies(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      build_random_body();
      // keep the item count near its budget
      while (body_q.size() > stop_at - items_sent) void'(body_q.pop_back());
      send_body($urandom_range(0, 14) != 0);
    end
  endtask

  // receiver: runs of always ready, coin-flip ready and mostly stalled
  always @(posedge clk) begin
    if (rdy_run == 0) begin
      rdy_mode <= $urandom_range(0, 2);
      rdy_run  <= $urandom_range(8, 60);
    end else begin
      rdy_run  <= rdy_run - 1;
    end
    case (rdy_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: kind %0d byte %0h",
               m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.chunk_end) begin
          $error("chunk_end: expected %0b, got %0b", want.chunk_end, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    line_limit = hcbd_pkg::MAX_LINE_LEN_RESET;
    clear_parser();

    test_simple_body();
    test_trailer_faults();
    test_size_overflow();
    test_random_bodies(115);
    drain_results();

    set_line_limit(16'd2);
    test_line_limit();
    test_random_bodies(40);
    drain_results();

    set_line_limit(16'hffff);
    test_random_bodies(110);
    drain_results();

    set_line_limit(16'd8);
    test_random_bodies(80);
    drain_results();

    set_line_limit(16'($urandom_range(3, 200)));
    test_random_bodies(70);
    drain_results();

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
